// File: rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds while reset is low
`define ASSERT_CLK_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/krdf_pkg.sv
`default_nettype none

package krdf_pkg;

    localparam int SC_W              = 7;
    localparam int TIME_W            = 32;
    localparam int DELAY_W           = 16;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;
    localparam int NUM_SCANCODES_DEF = 128;
    localparam int QUEUE_DEPTH       = 2;

    // operation codes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic              is_tick;
        logic [SC_W-1:0]   scancode;
        logic              press;
        logic              repeat_req;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        logic [SC_W-1:0] scancode;
        logic            press;
        logic            repeat_req;
        logic            last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/krdf_ram.sv
`default_nettype none

module krdf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/krdf_front.sv
`default_nettype none

module krdf_front #(
    parameter int NUM_SCANCODES = krdf_pkg::NUM_SCANCODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  krdf_pkg::item_t       in_item,
    output krdf_pkg::queue_head_t head,
    input  logic                  pop
);

    import krdf_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t         q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          keep;
    logic          push;
    logic          do_pop;

    // key events beyond the scancode range cause nothing and are dropped here
    assign keep     = in_item.is_tick || (32'(in_item.scancode) < 32'(NUM_SCANCODES));
    assign in_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/core/krdf_back.sv
`default_nettype none

module krdf_back #(
    parameter int NUM_SCANCODES = krdf_pkg::NUM_SCANCODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [krdf_pkg::DELAY_W-1:0]   cfg_data,
    input  krdf_pkg::queue_head_t          head,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output krdf_pkg::result_t              out_res
);

    import krdf_pkg::*;

    localparam int AW = $clog2(NUM_SCANCODES);
    localparam int XW = (AW > SC_W) ? AW : SC_W;

    localparam logic [1:0] ST_RD  = 2'd0;
    localparam logic [1:0] ST_EX  = 2'd1;
    localparam logic [1:0] ST_EX2 = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [DELAY_W-1:0]       delay_reg;
    logic [SC_W-1:0]          prev_key_reg, prev_key_next;
    logic                     prev_valid_reg, prev_valid_next;
    logic                     pend_reg, pend_next;
    logic [TIME_W-1:0]        since_reg, since_next;
    logic [NUM_SCANCODES-1:0] flag_valid_reg;
    logic                     ovalid_reg;
    result_t                  ores_reg;

    item_t             h;
    logic [XW-1:0]     sc_x, prev_x;
    logic [AW-1:0]     sc_addr, prev_addr;
    logic [0:0]        ram_q;
    logic              flag;
    logic              is_rel, is_plain;
    logic [TIME_W-1:0] elapsed;
    logic              timeout, same_key;
    logic              emit1, two, wr_prev, wr_sc;
    result_t           res1, res2;
    logic              can_load, ex_commit, ex2_commit;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [0:0]        ram_wdata;
    logic              load;
    result_t           load_res;

    assign h         = head.item;
    assign sc_x      = XW'(h.scancode);
    assign prev_x    = XW'(prev_key_reg);
    assign sc_addr   = sc_x[AW-1:0];
    assign prev_addr = prev_x[AW-1:0];

    // an entry never written since reset reads as not pressed
    assign flag = flag_valid_reg[sc_addr] & ram_q[0];

    assign is_rel   = !h.press && !h.repeat_req;
    assign is_plain = h.press && !h.repeat_req;
    assign elapsed  = h.now - since_reg;
    assign timeout  = pend_reg && (elapsed >= TIME_W'(delay_reg));
    assign same_key = prev_valid_reg && (prev_key_reg == h.scancode);

    assign res2 = '{scancode: h.scancode, press: h.press, repeat_req: h.repeat_req, last: 1'b1};

    always_comb
    begin
        emit1           = 1'b0;
        two             = 1'b0;
        wr_prev         = 1'b0;
        wr_sc           = 1'b0;
        res1            = '{scancode: h.scancode, press: h.press,
                            repeat_req: h.repeat_req, last: 1'b1};
        prev_key_next   = prev_key_reg;
        prev_valid_next = prev_valid_reg;
        pend_next       = pend_reg;
        since_next      = since_reg;
        if (h.is_tick)
        begin
            if (timeout)
            begin
                emit1           = 1'b1;
                res1            = '{scancode: prev_key_reg, press: 1'b0,
                                    repeat_req: 1'b0, last: 1'b1};
                wr_prev         = 1'b1;
                prev_key_next   = '0;
                prev_valid_next = 1'b0;
                pend_next       = 1'b0;
                since_next      = '0;
            end
        end
        else if (!(is_rel && !flag))
        begin
            if (!same_key)
            begin
                prev_key_next   = h.scancode;
                prev_valid_next = 1'b1;
                if (pend_reg)
                begin
                    // held release goes out first, the event follows
                    emit1      = 1'b1;
                    two        = 1'b1;
                    res1       = '{scancode: prev_key_reg, press: 1'b0,
                                   repeat_req: 1'b0, last: 1'b0};
                    wr_prev    = 1'b1;
                    pend_next  = 1'b0;
                    since_next = '0;
                end
                else
                begin
                    emit1 = 1'b1;
                    wr_sc = is_plain || is_rel;
                end
            end
            else if (!pend_reg && is_rel)
            begin
                pend_next  = 1'b1;
                since_next = h.now;
            end
            else if (pend_reg)
            begin
                // quick re-press swallows both the held release and itself
                if (is_plain)
                begin
                    pend_next  = 1'b0;
                    since_next = '0;
                    wr_sc      = 1'b1;
                end
            end
            else
            begin
                emit1 = 1'b1;
                wr_sc = is_plain;
            end
        end
    end

    assign can_load   = !ovalid_reg || out_ready;
    assign ex_commit  = (state_reg == ST_EX) && (!emit1 || can_load);
    assign ex2_commit = (state_reg == ST_EX2) && can_load;
    assign pop        = (ex_commit && !two) || ex2_commit;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sc_addr;
        ram_wdata = is_plain;
        load      = 1'b0;
        load_res  = res1;
        if (ex_commit)
        begin
            ram_we    = wr_prev || wr_sc;
            ram_waddr = wr_prev ? prev_addr : sc_addr;
            ram_wdata = wr_prev ? 1'b0 : is_plain;
            load      = emit1;
        end
        else if (ex2_commit)
        begin
            ram_we   = is_plain || is_rel;
            load     = 1'b1;
            load_res = res2;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RD:
            begin
                if (head.valid)
                begin
                    state_next = ST_EX;
                end
            end
            ST_EX:
            begin
                if (ex_commit)
                begin
                    state_next = two ? ST_EX2 : ST_RD;
                end
            end
            ST_EX2:
            begin
                if (ex2_commit)
                begin
                    state_next = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_RD;
            end
        endcase
    end

    krdf_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SCANCODES)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    ((state_reg == ST_RD) && head.valid),
        .raddr (sc_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RD;
            delay_reg      <= DELAY_RESET;
            prev_key_reg   <= '0;
            prev_valid_reg <= 1'b0;
            pend_reg       <= 1'b0;
            since_reg      <= '0;
            flag_valid_reg <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                delay_reg <= cfg_data;
            end
            if (ex_commit)
            begin
                prev_key_reg   <= prev_key_next;
                prev_valid_reg <= prev_valid_next;
                pend_reg       <= pend_next;
                since_reg      <= since_next;
            end
            if (ram_we)
            begin
                flag_valid_reg[ram_waddr] <= 1'b1;
            end
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ores_reg <= load_res;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;

endmodule

`default_nettype wire

// File: rtl/core/key_release_deferral_filter.sv
// channel   direction  handshake              payload
// config    in         cfg_write              cfg_data (release_delay)
// input     in         in_valid / in_ready    operation, scancode, press, repeat_req, now
// output    out        out_valid / out_ready  out_scancode, out_press, out_repeat, last_in_run
//
// an item passes the back end in steps (flag ram read, then execute, then a second
// execute step when it emits two results), one item at a time; the flag ram and the single result register set this
// the front queues up to two transactions, so input keeps flowing while a result waits
// reset is asynchronous; the pressed flags read as clear at once through per-entry
// valid bits, no clearing pass
// a stalled output holds the back end in its execute step; the queue then fills
`default_nettype none

module key_release_deferral_filter #(
    parameter int NUM_SCANCODES = krdf_pkg::NUM_SCANCODES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [krdf_pkg::DELAY_W-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [krdf_pkg::SC_W-1:0]    scancode,
    input  logic                         press,
    input  logic                         repeat_req,
    input  logic [krdf_pkg::TIME_W-1:0]  now,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [krdf_pkg::SC_W-1:0]    out_scancode,
    output logic                         out_press,
    output logic                         out_repeat,
    output logic                         last_in_run
);

    import krdf_pkg::*;

    item_t       in_item;
    queue_head_t head;
    logic        pop;
    result_t     out_res;

    assign in_item.is_tick    = (operation == OP_TICK);
    assign in_item.scancode   = scancode;
    assign in_item.press      = press;
    assign in_item.repeat_req = repeat_req;
    assign in_item.now        = now;

    krdf_front #(
        .NUM_SCANCODES (NUM_SCANCODES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .head     (head),
        .pop      (pop)
    );

    krdf_back #(
        .NUM_SCANCODES (NUM_SCANCODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign out_scancode = out_res.scancode;
    assign out_press    = out_res.press;
    assign out_repeat   = out_res.repeat_req;
    assign last_in_run  = out_res.last;

endmodule

`default_nettype wire

// File: rtl/core/krdf_checker.sv
`include "assert_macros.svh"
`default_nettype none

module krdf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [6:0] out_scancode,
    input wire logic       out_press,
    input wire logic       out_repeat,
    input wire logic       last_in_run
);

    logic       stall;
    logic       first_of_pair;
    logic [9:0] res_bits;

    assign stall         = out_valid && !out_ready;
    assign first_of_pair = out_valid && !last_in_run;
    assign res_bits      = {out_scancode, out_press, out_repeat, last_in_run};

    // a stalled result stays put
    `ASSERT_CLK(a_out_hold, stall |=> out_valid && $stable(res_bits), "stalled result changed")

    // the first of a pair is always the held release
    `ASSERT_CLK(a_first_rel, first_of_pair |-> !out_press && !out_repeat, "first of pair not a release")

    // the second of a pair is loaded on the edge that takes the first
    `ASSERT_CLK(a_pair_follows, first_of_pair && out_ready |=> out_valid, "second of a pair missing")

    `ASSERT_CLK_ANY(a_reset_idle, !rst_n |=> !out_valid, "result valid during reset")

endmodule

bind key_release_deferral_filter krdf_checker u_krdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_scancode (out_scancode),
    .out_press    (out_press),
    .out_repeat   (out_repeat),
    .last_in_run  (last_in_run)
);

`default_nettype wire

// File: tb/krdf_event_checker.sv
`timescale 1ns / 100ps

module krdf_event_checker
    import krdf_pkg::*;
#(
    parameter int NUM_SCANCODES = NUM_SCANCODES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [DELAY_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              operation,
    input  logic [SC_W-1:0]   scancode,
    input  logic              press,
    input  logic              repeat_req,
    input  logic [TIME_W-1:0] now,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [SC_W-1:0]   out_scancode,
    input  logic              out_press,
    input  logic              out_repeat,
    input  logic              last_in_run,
    output int                errors,
    output int                pending_results
);

    // shadow of the filter state
    logic [DELAY_W-1:0] delay_cfg;
    logic               key_down [NUM_SCANCODES];
    logic [SC_W-1:0]    recent_key;
    logic               recent_key_valid;
    logic               release_held;
    logic [TIME_W-1:0]  held_since;

    result_t filtered_events_due [$];
    result_t seen;

    initial errors = 0;

    task automatic report_mismatch(input string what);
        errors++;
        $display("%0t checker: %s", $time, what);
    endtask

    task automatic push_event(input logic [SC_W-1:0] sc, input logic pr, input logic rp);
        result_t r;
        r.scancode   = sc;
        r.press      = pr;
        r.repeat_req = rp;
        r.last       = 1'b0;
        filtered_events_due.push_back(r);
        // an emitted release clears the key
        if (!pr && !rp && int'(sc) < NUM_SCANCODES)
            key_down[sc] = 1'b0;
    endtask

    task automatic predict_filtered_events(
        input logic              op,
        input logic [SC_W-1:0]   sc,
        input logic              pr,
        input logic              rp,
        input logic [TIME_W-1:0] t
    );
        int                due_at_start;
        logic              is_release;
        logic              is_press;
        logic [TIME_W-1:0] elapsed;
        result_t           tail;
        due_at_start = filtered_events_due.size();
        is_release   = !pr && !rp;
        is_press     = pr && !rp;
        elapsed      = t - held_since;
        if (op == OP_TICK)
        begin
            if (release_held && elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay_cfg})
            begin
                push_event(recent_key, 1'b0, 1'b0);
                recent_key_valid = 1'b0;
                recent_key       = '0;
                held_since       = '0;
                release_held     = 1'b0;
            end
        end
        else if (int'(sc) < NUM_SCANCODES && !(is_release && !key_down[sc]))
        begin
            if (is_press)
                key_down[sc] = 1'b1;
            if (!recent_key_valid || recent_key != sc)
            begin
                if (release_held)
                begin
                    push_event(recent_key, 1'b0, 1'b0);
                    held_since   = '0;
                    release_held = 1'b0;
                end
                push_event(sc, pr, rp);
                recent_key       = sc;
                recent_key_valid = 1'b1;
            end
            else if (!release_held && is_release)
            begin
                held_since   = t;
                release_held = 1'b1;
            end
            else if (release_held)
            begin
                // a plain press of the held key swallows both, anything else is dropped
                if (is_press)
                begin
                    release_held = 1'b0;
                    held_since   = '0;
                end
            end
            else
                push_event(sc, pr, rp);
        end
        if (filtered_events_due.size() > due_at_start)
        begin
            tail = filtered_events_due.pop_back();
            tail.last = 1'b1;
            filtered_events_due.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg        = DELAY_RESET;
            recent_key       = '0;
            recent_key_valid = 1'b0;
            release_held     = 1'b0;
            held_since       = '0;
            for (int i = 0; i < NUM_SCANCODES; i++)
                key_down[i] = 1'b0;
            filtered_events_due.delete();
            pending_results = 0;
        end
        else
        begin
            // results first: a transaction at this edge belongs to an older input
            if (out_valid && out_ready)
            begin
                if (filtered_events_due.size() == 0)
                    report_mismatch($sformatf("unexpected transaction sc %0d press %0b repeat %0b",
                        out_scancode, out_press, out_repeat));
                else
                begin
                    seen = filtered_events_due.pop_front();
                    if (out_scancode != seen.scancode)
                        report_mismatch($sformatf("out_scancode %0d, expected %0d",
                            out_scancode, seen.scancode));
                    if (out_press != seen.press)
                        report_mismatch($sformatf("out_press %0b, expected %0b (sc %0d)",
                            out_press, seen.press, seen.scancode));
                    if (out_repeat != seen.repeat_req)
                        report_mismatch($sformatf("out_repeat %0b, expected %0b (sc %0d)",
                            out_repeat, seen.repeat_req, seen.scancode));
                    if (last_in_run != seen.last)
                        report_mismatch($sformatf("last_in_run %0b, expected %0b (sc %0d)",
                            last_in_run, seen.last, seen.scancode));
                end
            end
            if (in_valid && in_ready)
                predict_filtered_events(operation, scancode, press, repeat_req, now);
            if (cfg_write)
                delay_cfg = cfg_data;
            pending_results = filtered_events_due.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import krdf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS = 124;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [DELAY_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = OP_KEY;
    logic [SC_W-1:0]    scancode = '0;
    logic               press = 1'b0;
    logic               repeat_req = 1'b0;
    logic [TIME_W-1:0]  now = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SC_W-1:0]    out_scancode;
    logic               out_press;
    logic               out_repeat;
    logic               last_in_run;

    int                 errors;
    int                 pending_results;
    int                 cycle_count = 0;
    int                 items_sent = 0;
    int                 ready_hold = 0;
    logic               steady = 1'b0;
    logic [TIME_W-1:0]  stamp = '0;
    logic [DELAY_W-1:0] cur_delay = DELAY_RESET;

    always #1 clk = ~clk;

    key_release_deferral_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .scancode     (scancode),
        .press        (press),
        .repeat_req   (repeat_req),
        .now          (now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_scancode (out_scancode),
        .out_press    (out_press),
        .out_repeat   (out_repeat),
        .last_in_run  (last_in_run)
    );

    krdf_event_checker event_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .scancode        (scancode),
        .press           (press),
        .repeat_req      (repeat_req),
        .now             (now),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_scancode    (out_scancode),
        .out_press       (out_press),
        .out_repeat      (out_repeat),
        .last_in_run     (last_in_run),
        .errors          (errors),
        .pending_results (pending_results)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("key_release_deferral_filter regression: fail");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (steady)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            out_ready  <= ($urandom_range(0, 3) != 0);
            ready_hold <= gap_len();
        end
    end

    function automatic logic [SC_W-1:0] pick_key();
        case ($urandom_range(0, 4))
            0, 1, 2: return SC_W'($urandom_range(0, 7));
            3:       return $urandom_range(0, 1) ? {SC_W{1'b1}} : {SC_W{1'b0}};
            default: return SC_W'($urandom_range(0, 127));
        endcase
    endfunction

    // time step before a tick, clustered around the release delay
    function automatic logic [TIME_W-1:0] tick_step();
        logic [TIME_W-1:0] d;
        d = {{(TIME_W-DELAY_W){1'b0}}, cur_delay};
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 2);
            1:       return d - 1;
            2:       return d;
            3:       return d + 1;
            4:       return $urandom_range(0, 2 * d + 4);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(
        input logic              op,
        input logic [SC_W-1:0]   sc,
        input logic              pr,
        input logic              rp,
        input logic [TIME_W-1:0] t,
        input logic              counted
    );
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        scancode   <= sc;
        press      <= pr;
        repeat_req <= rp;
        now        <= t;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        if (counted)
            items_sent++;
    endtask

    task automatic key_event(input logic [SC_W-1:0] sc, input logic pr, input logic rp);
        stamp += $urandom_range(0, 3);
        send_item(OP_KEY, sc, pr, rp, stamp, 1'b1);
    endtask

    task automatic tick_event(input logic counted);
        stamp += tick_step();
        send_item(OP_TICK, SC_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), stamp, counted);
    endtask

    // wait until every result is in and the back end has drained
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] v);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        cur_delay  = v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_sequence();
        logic [SC_W-1:0] k;
        logic [SC_W-1:0] j;
        int              n;
        k = pick_key();
        j = pick_key();
        n = $urandom_range(1, 3);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // tap, release waits for a tick
                key_event(k, 1'b1, 1'b0);
                key_event(k, 1'b0, 1'b0);
                tick_event(1'b1);
                if ($urandom_range(0, 1))
                    tick_event(1'b1);
            end
            2:
            begin
                // bounce, second press swallows the held release
                key_event(k, 1'b1, 1'b0);
                key_event(k, 1'b0, 1'b0);
                key_event(k, 1'b1, 1'b0);
                key_event(k, 1'b0, 1'b0);
                tick_event(1'b1);
            end
            3:
            begin
                // roll onto another key
                key_event(k, 1'b1, 1'b0);
                key_event(k, 1'b0, 1'b0);
                key_event(j, 1'b1, 1'b0);
                key_event(j, 1'b0, 1'b0);
            end
            4:
            begin
                key_event(k, 1'b1, 1'b0);
                repeat (n) key_event(k, 1'b1, 1'b1);
                key_event(k, 1'b0, 1'b0);
                key_event(k, 1'($urandom_range(0, 1)), 1'b1);
                tick_event(1'b1);
            end
            5:
            begin
                stamp += 1;
                send_item(OP_KEY, pick_key(), 1'b0, 1'b0, stamp, 1'b0);
            end
            6:
                tick_event(1'b0);
            default:
                send_item(1'($urandom_range(0, 1)), SC_W'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                          1'b0);
        endcase
    endtask

    initial
    begin
        logic [DELAY_W-1:0] phase_delay [8];
        int                 target;
        phase_delay[0] = {DELAY_W{1'b1}};
        phase_delay[1] = 16'd1;
        phase_delay[2] = DELAY_RESET;
        phase_delay[3] = DELAY_W'($urandom_range(2, 200));
        phase_delay[4] = 16'd0;
        phase_delay[5] = DELAY_W'($urandom_range(0, 65535));
        phase_delay[6] = DELAY_W'($urandom_range(2, 40));
        phase_delay[7] = 16'd2;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset delay, then at zero delay
        send_item(OP_KEY, 7'd20, 1'b0, 1'b0, 32'd100, 1'b1);    // release of an unpressed key
        send_item(OP_TICK, 7'd0, 1'b0, 1'b0, 32'd100, 1'b1);    // nothing held
        send_item(OP_KEY, 7'd0, 1'b1, 1'b0, 32'd101, 1'b1);
        send_item(OP_KEY, 7'd0, 1'b0, 1'b0, 32'd102, 1'b1);
        send_item(OP_TICK, 7'd0, 1'b0, 1'b0, 32'd111, 1'b1);    // one short of the delay
        send_item(OP_TICK, 7'd0, 1'b0, 1'b0, 32'd112, 1'b1);
        send_item(OP_KEY, 7'd127, 1'b1, 1'b0, 32'd120, 1'b1);
        send_item(OP_KEY, 7'd127, 1'b0, 1'b0, 32'd121, 1'b1);
        send_item(OP_KEY, 7'd127, 1'b1, 1'b0, 32'd125, 1'b1);   // bounce
        send_item(OP_KEY, 7'd127, 1'b0, 1'b0, 32'd126, 1'b1);
        send_item(OP_KEY, 7'd5, 1'b1, 1'b0, 32'd127, 1'b1);     // held release then new key
        send_item(OP_KEY, 7'd5, 1'b1, 1'b1, 32'd128, 1'b1);
        send_item(OP_KEY, 7'd5, 1'b0, 1'b0, 32'd129, 1'b1);
        send_item(OP_KEY, 7'd5, 1'b1, 1'b1, 32'd130, 1'b1);     // repeat on the held key
        send_item(OP_KEY, 7'd5, 1'b0, 1'b1, 32'd131, 1'b1);
        send_item(OP_TICK, 7'd127, 1'b1, 1'b1, 32'd200, 1'b1);
        send_item(OP_KEY, 7'd64, 1'b0, 1'b1, 32'd201, 1'b1);
        send_item(OP_KEY, 7'd3, 1'b1, 1'b0, 32'hFFFF_FFF0, 1'b1);
        send_item(OP_KEY, 7'd3, 1'b0, 1'b0, 32'hFFFF_FFFE, 1'b1);
        send_item(OP_TICK, 7'd0, 1'b0, 1'b0, 32'h0000_0007, 1'b1); // elapsed across the wrap
        send_item(OP_TICK, 7'd0, 1'b0, 1'b0, 32'h0000_0008, 1'b1);
        send_item(OP_KEY, 7'd127, 1'b0, 1'b0, 32'd9, 1'b1);
        write_delay(16'd0);
        send_item(OP_KEY, 7'd42, 1'b1, 1'b0, 32'd5, 1'b1);
        send_item(OP_KEY, 7'd42, 1'b0, 1'b0, 32'd5, 1'b1);
        send_item(OP_TICK, 7'd42, 1'b0, 1'b0, 32'd5, 1'b1);     // zero delay, same stamp
        stamp = 32'd10;

        for (int p = 0; p < 8; p++)
        begin
            write_delay(phase_delay[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                steady = (p == 3) || ($urandom_range(0, 7) == 0);
                run_sequence();
            end
            steady = 1'b0;
        end

        settle();
        if (errors == 0)
            $display("key_release_deferral_filter regression: pass");
        else
            $display("key_release_deferral_filter regression: fail");
        $finish;
    end

endmodule
